[src/broyden_rank1_stiffness_update_defines.svh]
// Assertion macros shared by the stiffness update modules.
// Each macro expects signals named clk and rst in the using module.
`ifndef BROYDEN_RANK1_STIFFNESS_UPDATE_DEFINES_SVH
`define BROYDEN_RANK1_STIFFNESS_UPDATE_DEFINES_SVH

// Same-cycle implication.
`define BRS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/brs_pkg.sv]
// ----------------------------------------------------------------------------
// brs_pkg
// Types and fixed widths of the rank-one stiffness update.
// ----------------------------------------------------------------------------
package brs_pkg;

  localparam int FIELD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int NN_W      = 66;   // sum of up to eight squared values
  localparam int ACC_W     = 67;   // signed sum of up to eight products
  localparam int R_W       = 52;   // signed residual
  localparam int RMAG_W    = 50;   // residual magnitude
  localparam int RHALF_W   = 25;   // half of the residual magnitude
  localparam int NUM_W     = 98;   // dividend of the term division
  localparam logic [NUM_W-1:0] TERM_LIM = NUM_W'(1) << 62;

  typedef enum logic [1:0] {
    KIND_LOAD_K  = 2'd0,
    KIND_LOAD_V  = 2'd1,
    KIND_COMPUTE = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NORM_MUL,
    S_NORM_ACC,
    S_KD_RD,
    S_KD_MUL,
    S_KD_ACC,
    S_KD_FIN,
    S_EM_RD,
    S_EM_MUL1,
    S_EM_MUL2,
    S_EM_NUM,
    S_EM_DIV,
    S_EM_OUT
  } back_state_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] dim;
  } brs_cmd_t;

endpackage

[src/brs_ram.sv]
// ----------------------------------------------------------------------------
// brs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/brs_div.sv]
// ----------------------------------------------------------------------------
// brs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "broyden_rank1_stiffness_update_defines.svh"

module brs_div #(
  parameter int NUM_W = 98,
  parameter int DEN_W = 66
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] numq;
  logic [DEN_W-1:0] rem;
  logic [CW-1:0]    cnt;
  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [DEN_W:0]   rem_next;

  assign rem_sh   = {rem, numq[NUM_W-1]};
  assign ge       = rem_sh >= {1'b0, den};
  assign rem_next = ge ? (rem_sh - {1'b0, den}) : rem_sh;
  assign quot     = numq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      numq <= num;
      rem  <= '0;
      cnt  <= CW'(NUM_W);
    end else if (busy) begin
      numq <= {numq[NUM_W-2:0], ge};
      rem  <= rem_next[DEN_W-1:0];
      cnt  <= cnt - CW'(1);
    end
  end

  `BRS_ASSERT_NEXT(a_div_start_busy, start, busy, "divider did not go busy after start")

endmodule

[src/brs_front.sv]
// ----------------------------------------------------------------------------
// brs_front
// Accepts items, writes the matrix and vector stores, queues compute commands.
// ----------------------------------------------------------------------------
`include "broyden_rank1_stiffness_update_defines.svh"

module brs_front #(
  parameter int MAX_DIM = 8,
  parameter int EFF_W = 32,
  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int AW = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      kind,
  input  logic [2:0]                      row,
  input  logic [2:0]                      col,
  input  logic [31:0]                     stiffness_value,
  input  logic [31:0]                     disp_value,
  input  logic [31:0]                     force_value,
  input  logic                            cfg_write,
  input  logic [3:0]                      cfg_data,
  input  logic                            back_busy,
  input  logic                            cmd_take,
  output brs_pkg::brs_cmd_t               cmd,
  output logic                            ram_we,
  output logic [AW-1:0]                   ram_waddr,
  output logic [EFF_W-1:0]                ram_wdata,
  output logic [MAX_DIM-1:0][EFF_W-1:0]   d_vec,
  output logic [MAX_DIM-1:0][EFF_W-1:0]   f_vec
);

  logic       accept;
  logic       row_ok;
  logic       col_ok;
  logic       vec_we;
  logic       cmd_push;
  logic [3:0] dimension;
  logic [3:0] dim_eff;

  assign full      = cmd.valid | back_busy;
  assign accept    = push & ~full;
  assign row_ok    = {1'b0, row} < 4'(MAX_DIM);
  assign col_ok    = {1'b0, col} < 4'(MAX_DIM);
  assign ram_waddr = AW'(32'(row) * MAX_DIM + 32'(col));
  assign ram_wdata = stiffness_value[EFF_W-1:0];

  // Clamp the dimension into 1..MAX_DIM.
  assign dim_eff = (dimension == 4'd0) ? 4'd1 :
                   (dimension > 4'(MAX_DIM)) ? 4'(MAX_DIM) : dimension;

  always_comb begin
    ram_we   = 1'b0;
    vec_we   = 1'b0;
    cmd_push = 1'b0;
    unique case (kind)
      brs_pkg::KIND_LOAD_K:  ram_we   = accept & row_ok & col_ok;
      brs_pkg::KIND_LOAD_V:  vec_we   = accept & row_ok;
      brs_pkg::KIND_COMPUTE: cmd_push = accept;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= 4'd8;
      cmd.valid <= 1'b0;
      cmd.dim   <= 4'd1;
    end else begin
      if (cfg_write) begin
        dimension <= cfg_data;
      end
      if (cmd_push) begin
        cmd.valid <= 1'b1;
        cmd.dim   <= dim_eff;
      end else if (cmd_take) begin
        cmd.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vec_we) begin
      d_vec[row[IW-1:0]] <= disp_value[EFF_W-1:0];
      f_vec[row[IW-1:0]] <= force_value[EFF_W-1:0];
    end
  end

  `BRS_ASSERT_NEXT(a_compute_queued, accept && kind == brs_pkg::KIND_COMPUTE, cmd.valid, "compute transaction not queued")

endmodule

[src/brs_back.sv]
// ----------------------------------------------------------------------------
// brs_back
// Sequencer: norm, residual, per-element division and result register.
// ----------------------------------------------------------------------------
`include "broyden_rank1_stiffness_update_defines.svh"

module brs_back #(
  parameter int MAX_DIM = 8,
  parameter int EFF_W = 32,
  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int AW = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  brs_pkg::brs_cmd_t               cmd,
  output logic                            cmd_take,
  output logic                            busy,
  input  logic [MAX_DIM-1:0][EFF_W-1:0]   d_vec,
  input  logic [MAX_DIM-1:0][EFF_W-1:0]   f_vec,
  output logic                            ram_re,
  output logic [AW-1:0]                   ram_raddr,
  input  logic [EFF_W-1:0]                ram_rdata,
  input  logic                            pop,
  output logic                            empty,
  output logic [2:0]                      out_row,
  output logic [2:0]                      out_col,
  output logic [31:0]                     new_stiffness,
  output logic                            last,
  output logic                            zero_step,
  output logic                            saturated
);

  localparam int NN_W    = brs_pkg::NN_W;
  localparam int ACC_W   = brs_pkg::ACC_W;
  localparam int R_W     = brs_pkg::R_W;
  localparam int RMAG_W  = brs_pkg::RMAG_W;
  localparam int RHALF_W = brs_pkg::RHALF_W;
  localparam int NUM_W   = brs_pkg::NUM_W;
  localparam logic signed [63:0] HIV = (64'sd1 <<< (EFF_W - 1)) - 64'sd1;
  localparam logic signed [63:0] LOV = -HIV - 64'sd1;

  brs_pkg::back_state_t state, state_next;

  logic [3:0]                      n_r;
  logic [IW-1:0]                   i_r;
  logic [IW-1:0]                   j_r;
  logic                            zero_r;
  logic [NN_W-1:0]                 nn;
  logic signed [ACC_W-1:0]         s_acc;
  logic [63:0]                     prod;
  logic signed [63:0]              sprod;
  logic [63:0]                     acc_lo;
  logic [MAX_DIM-1:0]              rneg;
  logic [MAX_DIM-1:0][RMAG_W-1:0]  rmag;
  logic signed [31:0]              kreg;
  logic [31:0]                     res_v;
  logic                            res_sat;
  logic                            oval;

  logic                            last_i;
  logic                            last_j;
  logic                            slot_free;
  logic signed [EFF_W-1:0]         d_raw;
  logic signed [EFF_W-1:0]         f_raw;
  logic signed [EFF_W-1:0]         k_raw;
  logic signed [31:0]              d_cur;
  logic signed [31:0]              k_cur;
  logic [31:0]                     dm;
  logic [NN_W-1:0]                 nn_sum;
  logic signed [R_W-1:0]           kd_v;
  logic signed [R_W-1:0]           r_v;
  logic signed [R_W-1:0]           r_abs;
  logic [RMAG_W-1:0]               rm_cur;
  logic [NUM_W-1:0]                pmag;
  logic [NUM_W-1:0]                div_num;
  logic                            div_start;
  logic                            div_busy;
  logic                            div_done;
  logic [NUM_W-1:0]                div_quot;
  logic                            q_big;
  logic signed [63:0]              tmag;
  logic signed [63:0]              term;
  logic signed [63:0]              v_sum;
  logic                            v_hi;
  logic                            v_lo;

  assign last_i    = 4'(i_r) == n_r - 4'd1;
  assign last_j    = 4'(j_r) == n_r - 4'd1;
  assign slot_free = ~oval | pop;
  assign busy      = state != brs_pkg::S_IDLE;
  assign cmd_take  = (state == brs_pkg::S_IDLE) & cmd.valid;
  assign ram_raddr = AW'(32'(i_r) * MAX_DIM + 32'(j_r));
  assign ram_re    = (state == brs_pkg::S_KD_RD) | (state == brs_pkg::S_EM_RD);
  assign div_start = state == brs_pkg::S_EM_NUM;

  assign d_raw  = d_vec[j_r];
  assign f_raw  = f_vec[i_r];
  assign k_raw  = ram_rdata;
  assign d_cur  = 32'(d_raw);
  assign k_cur  = 32'(k_raw);
  assign dm     = d_cur[31] ? (~d_cur + 32'd1) : d_cur;
  assign nn_sum = nn + NN_W'(prod);

  // Residual: f minus floor of the Q16.16 row product.
  assign kd_v  = R_W'(s_acc >>> brs_pkg::FRAC_BITS);
  assign r_v   = R_W'(f_raw) - kd_v;
  assign r_abs = r_v[R_W-1] ? -r_v : r_v;

  // Dividend: |r|*|d| scaled by 2^16, plus half the norm for rounding.
  assign rm_cur  = rmag[i_r];
  assign pmag    = (NUM_W'(prod) << RHALF_W) + NUM_W'(acc_lo);
  assign div_num = (pmag << brs_pkg::FRAC_BITS) + NUM_W'(nn[NN_W-1:1]);

  assign q_big = div_quot > brs_pkg::TERM_LIM;
  assign tmag  = q_big ? 64'(brs_pkg::TERM_LIM) : 64'(div_quot[62:0]);
  assign term  = (rneg[i_r] ^ d_cur[31]) ? -tmag : tmag;
  assign v_sum = 64'(kreg) + term;
  assign v_hi  = v_sum > HIV;
  assign v_lo  = v_sum < LOV;

  brs_div #(
    .NUM_W (NUM_W),
    .DEN_W (NN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (nn),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      brs_pkg::S_IDLE:     if (cmd.valid) state_next = brs_pkg::S_NORM_MUL;
      brs_pkg::S_NORM_MUL: state_next = brs_pkg::S_NORM_ACC;
      brs_pkg::S_NORM_ACC: begin
        if (!last_j) begin
          state_next = brs_pkg::S_NORM_MUL;
        end else if (nn_sum == '0) begin
          state_next = brs_pkg::S_EM_RD;
        end else begin
          state_next = brs_pkg::S_KD_RD;
        end
      end
      brs_pkg::S_KD_RD:    state_next = brs_pkg::S_KD_MUL;
      brs_pkg::S_KD_MUL:   state_next = brs_pkg::S_KD_ACC;
      brs_pkg::S_KD_ACC:   state_next = last_j ? brs_pkg::S_KD_FIN : brs_pkg::S_KD_RD;
      brs_pkg::S_KD_FIN:   state_next = last_i ? brs_pkg::S_EM_RD : brs_pkg::S_KD_RD;
      brs_pkg::S_EM_RD:    state_next = brs_pkg::S_EM_MUL1;
      brs_pkg::S_EM_MUL1:  state_next = zero_r ? brs_pkg::S_EM_OUT : brs_pkg::S_EM_MUL2;
      brs_pkg::S_EM_MUL2:  state_next = brs_pkg::S_EM_NUM;
      brs_pkg::S_EM_NUM:   state_next = brs_pkg::S_EM_DIV;
      brs_pkg::S_EM_DIV:   if (div_done) state_next = brs_pkg::S_EM_OUT;
      brs_pkg::S_EM_OUT: begin
        if (slot_free) begin
          state_next = (last_i && last_j) ? brs_pkg::S_IDLE : brs_pkg::S_EM_RD;
        end
      end
      default:             state_next = brs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oval <= 1'b0;
    end else begin
      if (pop && oval) begin
        oval <= 1'b0;
      end
      if (state == brs_pkg::S_EM_OUT && slot_free) begin
        oval <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      brs_pkg::S_IDLE: begin
        n_r   <= cmd.dim;
        i_r   <= '0;
        j_r   <= '0;
        nn    <= '0;
        s_acc <= '0;
      end
      brs_pkg::S_NORM_MUL: prod <= dm * dm;
      brs_pkg::S_NORM_ACC: begin
        nn     <= nn_sum;
        zero_r <= nn_sum == '0;
        j_r    <= last_j ? '0 : j_r + IW'(1);
      end
      brs_pkg::S_KD_RD: ;
      brs_pkg::S_KD_MUL:   sprod <= k_cur * d_cur;
      brs_pkg::S_KD_ACC: begin
        s_acc <= s_acc + ACC_W'(sprod);
        if (!last_j) begin
          j_r <= j_r + IW'(1);
        end
      end
      brs_pkg::S_KD_FIN: begin
        rneg[i_r] <= r_v[R_W-1];
        rmag[i_r] <= RMAG_W'(r_abs);
        s_acc     <= '0;
        j_r       <= '0;
        i_r       <= last_i ? '0 : i_r + IW'(1);
      end
      brs_pkg::S_EM_RD: ;
      brs_pkg::S_EM_MUL1: begin
        kreg    <= k_cur;
        res_v   <= k_cur;
        res_sat <= 1'b0;
        prod    <= rm_cur[RHALF_W-1:0] * dm;
      end
      brs_pkg::S_EM_MUL2: begin
        acc_lo <= prod;
        prod   <= rm_cur[RMAG_W-1:RHALF_W] * dm;
      end
      brs_pkg::S_EM_NUM: ;
      brs_pkg::S_EM_DIV: begin
        if (div_done) begin
          res_sat <= q_big | v_hi | v_lo;
          res_v   <= v_hi ? HIV[31:0] : (v_lo ? LOV[31:0] : v_sum[31:0]);
        end
      end
      brs_pkg::S_EM_OUT: begin
        if (slot_free) begin
          out_row       <= 3'(i_r);
          out_col       <= 3'(j_r);
          new_stiffness <= res_v;
          last          <= last_i & last_j;
          zero_step     <= zero_r;
          saturated     <= res_sat;
          if (last_j) begin
            j_r <= '0;
            i_r <= i_r + IW'(1);
          end else begin
            j_r <= j_r + IW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign empty = ~oval;

  `BRS_ASSERT_IMPL(a_div_start_free, div_start, !div_busy, "divider started while busy")
  `BRS_ASSERT_NEXT(a_last_to_idle, state == brs_pkg::S_EM_OUT && slot_free && last_i && last_j, state == brs_pkg::S_IDLE && oval && last, "final element did not close the matrix")

endmodule

[src/broyden_rank1_stiffness_update.sv]
// ----------------------------------------------------------------------------
// broyden_rank1_stiffness_update
// Rank-one secant update of a square Q16.16 stiffness matrix.
// ----------------------------------------------------------------------------
//  channel   direction  handshake        payload
//  input     in         push / full      kind, row, col, stiffness_value,
//                                        disp_value, force_value
//  result    out        empty / pop      out_row, out_col, new_stiffness,
//                                        last, zero_step, saturated
//  config    in         cfg_write        cfg_data (dimension)
//
//  Load transactions are accepted back to back.
//  A compute transaction with n = dimension runs the norm, the residual and,
//  per element, the restoring divider on a NUM_W = 98 bit dividend, one
//  quotient bit per cycle. A zero displacement skips the residual and the divider.
//  While a compute is queued or running, full stays high.
//  A result waits in the output register; while it is full and pop is low the sequencer holds.
//  Reset is synchronous; the stores come up undefined and need no clearing.
// ----------------------------------------------------------------------------
module broyden_rank1_stiffness_update #(
  parameter int MAX_DIM = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind,
  input  logic [2:0]  row,
  input  logic [2:0]  col,
  input  logic [31:0] stiffness_value,
  input  logic [31:0] disp_value,
  input  logic [31:0] force_value,
  input  logic        cfg_write,
  input  logic [3:0]  cfg_data,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_row,
  output logic [2:0]  out_col,
  output logic [31:0] new_stiffness,
  output logic        last,
  output logic        zero_step,
  output logic        saturated
);

  // Stored values are the low EFF_W bits, sign-extended where they are used.
  localparam int EFF_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  brs_pkg::brs_cmd_t             cmd;
  logic                          cmd_take;
  logic                          back_busy;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [EFF_W-1:0]              ram_wdata;
  logic                          ram_re;
  logic [AW-1:0]                 ram_raddr;
  logic [EFF_W-1:0]              ram_rdata;
  logic [MAX_DIM-1:0][EFF_W-1:0] d_vec;
  logic [MAX_DIM-1:0][EFF_W-1:0] f_vec;

  // Front: decode transactions, fill the stores, queue compute commands.
  brs_front #(
    .MAX_DIM (MAX_DIM),
    .EFF_W   (EFF_W)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .kind            (kind),
    .row             (row),
    .col             (col),
    .stiffness_value (stiffness_value),
    .disp_value      (disp_value),
    .force_value     (force_value),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .back_busy       (back_busy),
    .cmd_take        (cmd_take),
    .cmd             (cmd),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .d_vec           (d_vec),
    .f_vec           (f_vec)
  );

  // Matrix store, row-major, MAX_DIM entries per row.
  brs_ram #(
    .WIDTH (EFF_W),
    .DEPTH (DEPTH)
  ) u_kstore (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Back: norm, residual, per-element term and the result register.
  brs_back #(
    .MAX_DIM (MAX_DIM),
    .EFF_W   (EFF_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cmd_take      (cmd_take),
    .busy          (back_busy),
    .d_vec         (d_vec),
    .f_vec         (f_vec),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .pop           (pop),
    .empty         (empty),
    .out_row       (out_row),
    .out_col       (out_col),
    .new_stiffness (new_stiffness),
    .last          (last),
    .zero_step     (zero_step),
    .saturated     (saturated)
  );

endmodule
